/* rtl/wildcard_byte_pattern_scanner_macros.svh */
// ----------------------------------------------------------------------------
// Wildcard byte pattern scanner: assertion macros
// Shared concurrent check forms; each expects clk and rst in the module scope.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_BYTE_PATTERN_SCANNER_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SCANNER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define WBPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define WBPS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/wbps_pkg.sv */
// ----------------------------------------------------------------------------
// Wildcard byte pattern scanner: package
// Shared types, register codes and field widths.
// ----------------------------------------------------------------------------
package wbps_pkg;

  localparam int ADDR_W    = 32;
  localparam int LEN_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;
  localparam int PAT_BYTES = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CARE_MASK      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd3;

  typedef struct packed {
    logic [8*PAT_BYTES-1:0] pattern;        // byte k at bits 8k+7:8k
    logic [PAT_BYTES-1:0]   care_mask;
    logic [LEN_W-1:0]       pattern_length;
  } cfg_t;

  typedef struct packed {
    logic [7:0]        data_byte;
    logic [ADDR_W-1:0] region_base;
    logic              first_of_region;
    logic              start_of_scan;
    logic              end_of_scan;
  } item_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] match_address;
  } res_t;

endpackage

/* rtl/wbps_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Wildcard byte pattern scanner: configuration registers
// Holds pattern, care mask and length written through the config channel.
// ----------------------------------------------------------------------------
module wbps_cfg_regs
  import wbps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_regs;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PATTERN_LOW:    cfg_regs.pattern[63:0]   <= cfg_data;
        CFG_PATTERN_HIGH:   cfg_regs.pattern[127:64] <= cfg_data;
        CFG_CARE_MASK:      cfg_regs.care_mask       <= cfg_data[PAT_BYTES-1:0];
        CFG_PATTERN_LENGTH: cfg_regs.pattern_length  <= cfg_data[LEN_W-1:0];
      endcase
    end
  end

endmodule

/* rtl/wbps_core.sv */
// ----------------------------------------------------------------------------
// Wildcard byte pattern scanner: match core
// Byte window, region offset and reported flag; masked compare per byte.
// ----------------------------------------------------------------------------
module wbps_core
  import wbps_pkg::*;
#(
  parameter int MAX_PATTERN = 16
)
(
  input  logic  clk,
  input  logic  rst,
  input  logic  advance,
  input  item_t item,
  input  cfg_t  cfg,
  output logic  res_valid,
  output res_t  res
);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

  logic [7:0]        window     [MAX_PATTERN];
  logic [7:0]        window_next[MAX_PATTERN];
  logic [ADDR_W-1:0] region_offset;
  logic              reported;

  logic              restart;
  logic [ADDR_W-1:0] offset_eff;
  logic              reported_eff;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  len_m1;
  logic              filled_ok;
  logic              mismatch;
  logic [LEN_W-1:0]  sel;
  logic [7:0]        win_byte;
  logic              hit;
  logic [ADDR_W-1:0] start_off;
  logic [ADDR_W-1:0] addr;

  assign restart      = item.first_of_region | item.start_of_scan;
  assign offset_eff   = restart ? '0 : region_offset;
  assign reported_eff = item.start_of_scan ? 1'b0 : reported;
  assign len          = (cfg.pattern_length > MAX_LEN) ? MAX_LEN : cfg.pattern_length;
  assign len_m1       = len - LEN_W'(1);
  assign filled_ok    = offset_eff >= ADDR_W'(len_m1);

  // Shift the new byte in at the newest end
  always_comb begin
    window_next[0] = item.data_byte;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      window_next[k] = window[k-1];
    end
  end

  // Pattern byte i lines up with window position len-1-i
  always_comb begin
    mismatch = 1'b0;
    sel      = '0;
    win_byte = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      sel      = len_m1 - LEN_W'(i);
      win_byte = '0;
      for (int j = 0; j < MAX_PATTERN; j++) begin
        if (sel == LEN_W'(j)) begin
          win_byte = window_next[j];
        end
      end
      if ((LEN_W'(i) < len) && cfg.care_mask[i] &&
          (win_byte != cfg.pattern[8*i +: 8])) begin
        mismatch = 1'b1;
      end
    end
  end

  assign hit       = (len == '0) || (filled_ok && !mismatch);
  assign start_off = (len == '0) ? '0 : offset_eff - ADDR_W'(len_m1);
  assign addr      = item.region_base + start_off;

  assign res_valid         = !reported_eff && (hit || item.end_of_scan);
  assign res.found         = hit;
  assign res.match_address = hit ? addr : '0;

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        window[k] <= window_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      region_offset <= '0;
      reported      <= 1'b0;
    end else if (advance) begin
      region_offset <= offset_eff + ADDR_W'(1);
      reported      <= reported_eff | hit | item.end_of_scan;
    end
  end

endmodule

/* rtl/wildcard_byte_pattern_scanner.sv */
// ----------------------------------------------------------------------------
// Wildcard byte pattern scanner: top level
// Finds the first masked pattern match in a region-split byte stream.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   in        sink       in_valid/in_ready    data_byte, region_base,
//                                             first_of_region, start_of_scan,
//                                             end_of_scan
//   out       source     out_valid/out_ready  found, match_address
//   cfg       sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One byte per cycle sustained while the output drains; a request's result
// passes from the input register through the compare into the result
// register, from which it is offered.
// The compare stage advances whenever the result register is empty or being
// drained, so a stalled output holds one result plus one waiting request.
// Synchronous active-high reset clears control state and all config registers.
// Config writes complete in the cycle they are presented.
// ----------------------------------------------------------------------------
`include "wildcard_byte_pattern_scanner_macros.svh"

module wildcard_byte_pattern_scanner
  import wbps_pkg::*;
#(
  parameter int MAX_PATTERN = 16
)
(
  input  logic                  clk,
  input  logic                  rst,
  // input byte channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            data_byte,
  input  logic [ADDR_W-1:0]     region_base,
  input  logic                  first_of_region,
  input  logic                  start_of_scan,
  input  logic                  end_of_scan,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  found,
  output logic [ADDR_W-1:0]     match_address,
  // configuration channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg;
  item_t s1_item;
  logic  s1_valid;
  logic  s1_adv;
  logic  in_fire;
  logic  core_res_valid;
  res_t  core_res;
  res_t  out_res;

  wbps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Advance the held request once the result slot is free or draining
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign in_fire  = in_valid && in_ready;

  // Input register: capture the request, hold it while the output stalls
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item.data_byte       <= data_byte;
      s1_item.region_base     <= region_base;
      s1_item.first_of_region <= first_of_region;
      s1_item.start_of_scan   <= start_of_scan;
      s1_item.end_of_scan     <= end_of_scan;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_fire || (s1_valid && !s1_adv);
    end
  end

  // Window compare and per-scan bookkeeping
  wbps_core #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (s1_adv),
    .item      (s1_item),
    .cfg       (cfg),
    .res_valid (core_res_valid),
    .res       (core_res)
  );

  // Result register: load a fresh result, otherwise drop the taken one
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      priority if (s1_adv && core_res_valid) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end else begin
        out_valid <= out_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && core_res_valid) begin
      out_res <= core_res;
    end
  end

  assign found         = out_res.found;
  assign match_address = out_res.match_address;

  // A not-found result carries a zero address
  `WBPS_ASSERT_IMP(a_notfound_zero, out_valid && !found, match_address == '0, "address not zero")
  // A result produced on advance must show up in the result register
  `WBPS_ASSERT_NXT(a_result_lands, s1_adv && core_res_valid, out_valid, "result not registered")
  // An empty input register never refuses a request
  `WBPS_ASSERT_IMP(a_ready_when_empty, !s1_valid, in_ready, "input register empty but not ready")
  // A held request stays put while the result slot is blocked
  `WBPS_ASSERT_NXT(a_hold_stalled, !in_ready, s1_valid && $stable(s1_item), "held request changed")

endmodule

/* tb/sv/wbps_scan_checker.sv */
// ----------------------------------------------------------------------------
// Wildcard byte pattern scanner: scan checker
// Watches the byte, result and register channels, predicts each scan result
// from its own copy of the pattern settings and window, and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wbps_scan_checker
  import wbps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [7:0]            data_byte,
  input  logic [ADDR_W-1:0]     region_base,
  input  logic                  first_of_region,
  input  logic                  start_of_scan,
  input  logic                  end_of_scan,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  found,
  input  logic [ADDR_W-1:0]     match_address,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    results_due
);

  cfg_t                      pattern_cfg;
  logic [PAT_BYTES-1:0][7:0] window;        // index 0 holds the newest byte
  logic [ADDR_W-1:0]         region_pos;
  logic                      scan_reported;
  res_t                      scan_results_q[$];
  int                        fail_count = 0;

  task automatic scan_byte(input logic [7:0] b, input logic [ADDR_W-1:0] base,
                           input logic first, input logic start, input logic last);
    int                n;
    logic [ADDR_W:0]   seen;
    logic [ADDR_W-1:0] start_off;
    logic              hit;
    res_t              due;
    n = (pattern_cfg.pattern_length > PAT_BYTES) ? PAT_BYTES
                                                 : int'(pattern_cfg.pattern_length);
    if (start) scan_reported = 1'b0;
    if (first || start) region_pos = '0;
    window = {window[PAT_BYTES-2:0], b};
    seen = {1'b0, region_pos} + 1'b1;
    start_off = '0;
    hit = 1'b0;
    if (n == 0) begin
      hit = 1'b1;
    end else if (seen >= n) begin
      hit = 1'b1;
      for (int k = 0; k < n; k++)
        if (pattern_cfg.care_mask[k] && pattern_cfg.pattern[8*k +: 8] != window[n-1-k])
          hit = 1'b0;
      start_off = region_pos + 1'b1 - ADDR_W'(n);
    end
    if (!scan_reported) begin
      if (hit) begin
        due = '{found: 1'b1, match_address: base + start_off};
        scan_results_q.insert(scan_results_q.size(), due);
        scan_reported = 1'b1;
      end else if (last) begin
        due = '{found: 1'b0, match_address: '0};
        scan_results_q.insert(scan_results_q.size(), due);
      end
    end
    if (last) scan_reported = 1'b1;
    region_pos = region_pos + 1'b1;
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      pattern_cfg   = '0;
      window        = '0;
      region_pos    = '0;
      scan_reported = 1'b0;
      scan_results_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PATTERN_LOW:    pattern_cfg.pattern[63:0]   = cfg_data;
          CFG_PATTERN_HIGH:   pattern_cfg.pattern[127:64] = cfg_data;
          CFG_CARE_MASK:      pattern_cfg.care_mask       = cfg_data[PAT_BYTES-1:0];
          CFG_PATTERN_LENGTH: pattern_cfg.pattern_length  = cfg_data[LEN_W-1:0];
        endcase
      end
      if (in_valid && in_ready)
        scan_byte(data_byte, region_base, first_of_region, start_of_scan, end_of_scan);
      if (out_valid && out_ready) begin
        if (scan_results_q.size() == 0) begin
          $error("unexpected result: found %0b, match_address %08h", found, match_address);
          fail_count++;
        end else begin
          want = scan_results_q.pop_front();
          if (found !== want.found) begin
            $error("found: expected %0b, actual %0b", want.found, found);
            fail_count++;
          end
          if (match_address !== want.match_address) begin
            $error("match_address: expected %08h, actual %08h",
                   want.match_address, match_address);
            fail_count++;
          end
        end
      end
    end
    results_due <= scan_results_q.size();
    mismatches  <= fail_count;
  end

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// Wildcard byte pattern scanner: testbench top
// Drives byte requests and register writes under varying idle patterns and
// hands all checking to the scan checker; gives the verdict at the end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import wbps_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  // Two pipeline stages inside the block; the settle wait covers any request
  // still in flight when the last expected result has gone out.
  localparam int SETTLE_CYCLES = 6;
  // Long receiver hold-off, enough to fill the block and stall its input.
  localparam int LONG_HOLD     = 80;
  // Cap on the run, well above the slowest correct run (every byte
  // behind a sender gap and a receiver stall).
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASE_ITEMS   = 170;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [7:0]            data_byte = '0;
  logic [ADDR_W-1:0]     region_base = '0;
  logic                  first_of_region = 1'b0;
  logic                  start_of_scan = 1'b0;
  logic                  end_of_scan = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  found;
  logic [ADDR_W-1:0]     match_address;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    mismatches;
  int                    results_due;

  // Stimulus knobs and the pattern currently loaded, used to plant matches.
  int                    send_gap_pct = 0;
  int                    take_gap_pct = 0;
  logic                  hold_start = 1'b0;
  logic [8*PAT_BYTES-1:0] cur_pattern = '0;
  logic [LEN_W-1:0]      cur_len = '0;
  int                    cycle_count = 0;

  wildcard_byte_pattern_scanner i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .data_byte       (data_byte),
    .region_base     (region_base),
    .first_of_region (first_of_region),
    .start_of_scan   (start_of_scan),
    .end_of_scan     (end_of_scan),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .found           (found),
    .match_address   (match_address),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  wbps_scan_checker i_scan_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .data_byte       (data_byte),
    .region_base     (region_base),
    .first_of_region (first_of_region),
    .start_of_scan   (start_of_scan),
    .end_of_scan     (end_of_scan),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .found           (found),
    .match_address   (match_address),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .results_due     (results_due)
  );

  always #5 clk = ~clk;

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: random back-pressure, or one long hold-off when asked.
  // The hold-off is counted here so the sender keeps offering meanwhile.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_start) begin
        out_ready <= 1'b0;
        hold_left = LONG_HOLD;
      end else begin
        out_ready <= ($urandom_range(99) >= take_gap_pct);
      end
    end
  end

  // Offer one byte request, idling first at the current sender rate, and
  // hold it until the block takes it. Valid stays high on return so that a
  // following request goes out without a bubble.
  task automatic send_byte(input logic [7:0] b, input logic [ADDR_W-1:0] base,
                           input logic first, input logic start, input logic last);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    data_byte       <= b;
    region_base     <= base;
    first_of_region <= first;
    start_of_scan   <= start;
    end_of_scan     <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  // Send one region's bytes; flags mark its first and last byte.
  task automatic send_run(input byte_q_t bytes, input logic [ADDR_W-1:0] base,
                          input logic first, input logic start, input logic last);
    foreach (bytes[i])
      send_byte(bytes[i], base, (i == 0) && first, (i == 0) && start,
                (i == bytes.size() - 1) && last);
  endtask

  // Drop valid, wait out every expected result, then let the pipeline empty.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Load a full pattern setting once the block has gone quiet. Unused upper
  // bits of the narrow registers carry junk half the time; they must be dropped.
  task automatic write_setting(input logic [8*PAT_BYTES-1:0] pattern,
                               input logic [PAT_BYTES-1:0] care, input logic [LEN_W-1:0] len);
    logic [CFG_DATA_W-1:0] junk;
    settle();
    junk = ($urandom_range(1) == 0) ? '0 : {$urandom(), $urandom()};
    cur_pattern = pattern;
    cur_len     = len;
    write_reg(CFG_PATTERN_LOW, pattern[63:0]);
    write_reg(CFG_PATTERN_HIGH, pattern[127:64]);
    write_reg(CFG_CARE_MASK, {junk[CFG_DATA_W-1:PAT_BYTES], care});
    write_reg(CFG_PATTERN_LENGTH, {junk[CFG_DATA_W-1:LEN_W], len});
    cfg_valid <= 1'b0;
  endtask

  // One well-formed scan of one or more regions, with the pattern planted in
  // most regions, sometimes cut short by the region end. Now and then leave
  // the scan without its last byte, and follow it with stray bytes.
  task automatic random_scan(inout int sent);
    int                regions;
    int                rlen;
    int                at;
    int                eff;
    logic              open_end;
    logic [ADDR_W-1:0] base;
    byte_q_t           bytes;
    regions  = ($urandom_range(3) == 0) ? $urandom_range(2, 4) : 1;
    open_end = ($urandom_range(9) == 0);
    eff      = (cur_len > PAT_BYTES) ? PAT_BYTES : int'(cur_len);
    for (int r = 0; r < regions; r++) begin
      rlen = ($urandom_range(15) == 0) ? $urandom_range(24, 64) : $urandom_range(1, 20);
      bytes.delete();
      repeat (rlen) bytes.insert(bytes.size(), 8'($urandom()));
      if ($urandom_range(9) < 6) begin
        at = $urandom_range(rlen - 1);
        // End the match on the region's last byte every so often.
        if ($urandom_range(3) == 0 && rlen >= eff) at = rlen - eff;
        for (int k = 0; k < eff && at + k < rlen; k++)
          bytes[at + k] = cur_pattern[8*k +: 8];
      end
      // Bases near the top of the address space make the sum wrap.
      base = ($urandom_range(7) == 0) ? ADDR_W'(32'hFFFF_FFFF - $urandom_range(8))
                                      : ADDR_W'($urandom());
      // A scan start alone must restart the region too, so drop the region
      // flag on the opening byte now and then.
      send_run(bytes, base, (r != 0) || ($urandom_range(3) != 0), r == 0,
               (r == regions - 1) && !open_end);
      sent += rlen;
    end
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 3))
        send_byte(8'($urandom()), ADDR_W'($urandom()), 1'($urandom_range(1)), 1'b0,
                  1'($urandom_range(1)));
  endtask

  // Random part of a phase: pick a setting, run a few scans, repeat.
  task automatic run_phase(input int item_goal);
    int                     sent;
    logic [8*PAT_BYTES-1:0] pat;
    logic [PAT_BYTES-1:0]   care;
    logic [LEN_W-1:0]       len;
    sent = 0;
    while (sent < item_goal) begin
      pat  = {$urandom(), $urandom(), $urandom(), $urandom()};
      care = PAT_BYTES'($urandom() | $urandom());
      len  = LEN_W'($urandom_range(1, 8));
      case ($urandom_range(9))
        0: len = '0;                                         // empty pattern
        1: len = LEN_W'($urandom_range(17, 31));             // over-long
        2: begin
          len  = LEN_W'(PAT_BYTES);
          care = '1;
        end
        3: begin                                             // all wildcards
          len  = LEN_W'($urandom_range(1, PAT_BYTES));
          care = '0;
        end
        4: begin
          pat = {(8*PAT_BYTES){1'($urandom_range(1))}};
          len = LEN_W'($urandom_range(9, PAT_BYTES));
        end
        5: len = LEN_W'($urandom_range(9, PAT_BYTES));
        default: ;
      endcase
      write_setting(pat, care, len);
      repeat ($urandom_range(3, 8)) random_scan(sent);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Phase one: sender mostly busy, receiver mostly stalled.
    send_gap_pct = 22;
    take_gap_pct = 71;

    // Pattern DE AD ?? EF: byte two is a wildcard.
    write_setting(128'hEFBE_ADDE, 16'h000B, 5'd4);
    // Plain hit one byte into the region.
    send_run('{8'h00, 8'hDE, 8'hAD, 8'h55, 8'hEF, 8'h7F}, 32'h0000_1000, 1'b1, 1'b1, 1'b1);
    // Pattern split across two regions: must not match, so not-found.
    send_run('{8'hDE, 8'hAD}, 32'h0000_2000, 1'b1, 1'b1, 1'b0);
    send_run('{8'hBE, 8'hEF}, 32'h0000_3000, 1'b1, 1'b0, 1'b1);
    // Full match after the scan has ended: drop it silently.
    send_run('{8'hDE, 8'hAD, 8'hBE, 8'hEF}, 32'h0000_4000, 1'b1, 1'b0, 1'b0);
    // Scan start without region flag, hit on the last byte, address wraps.
    send_run('{8'h11, 8'h22, 8'hDE, 8'hAD, 8'h00, 8'hEF}, 32'hFFFF_FFFE, 1'b0, 1'b1, 1'b1);
    // Empty pattern hits on the first byte; the closing byte adds nothing.
    write_setting('1, '1, 5'd0);
    send_run('{8'hFF, 8'h00}, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);

    run_phase(PHASE_ITEMS);

    // Phase two: roles swapped.
    send_gap_pct = 71;
    take_gap_pct = 22;
    run_phase(PHASE_ITEMS);

    // Phase three: no idling. Open with one-byte scans under an empty
    // pattern, each giving a result, while the receiver holds off long
    // enough for the block to back up and refuse requests.
    send_gap_pct = 0;
    take_gap_pct = 0;
    write_setting({$urandom(), $urandom(), $urandom(), $urandom()}, 16'hFFFF, 5'd0);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    repeat (24) send_byte(8'($urandom()), ADDR_W'($urandom()), 1'b1, 1'b1, 1'b1);
    run_phase(PHASE_ITEMS);

    settle();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/wbps_pkg.sv
rtl/wbps_cfg_regs.sv
rtl/wbps_core.sv
rtl/wildcard_byte_pattern_scanner.sv
tb/sv/wbps_scan_checker.sv
tb/sv/testbench.sv
